[src/acbt_pkg.sv]
`default_nettype none

package acbt_pkg;

    localparam int ACBT_NODE_W    = 16;
    localparam int ACBT_NODES     = 1 << ACBT_NODE_W;
    localparam int ACBT_ALT_W     = 32;
    localparam int ACBT_LIMIT_W   = ACBT_ALT_W + 1;
    localparam int ACBT_MODE_W    = 2;
    localparam int ACBT_CFG_IDX_W = 1;
    localparam int ACBT_LEVELS    = 17;

    localparam logic [ACBT_CFG_IDX_W-1:0] REG_ROOT_NODE  = ACBT_CFG_IDX_W'(0);
    localparam logic [ACBT_CFG_IDX_W-1:0] REG_NODE_COUNT = ACBT_CFG_IDX_W'(1);

    typedef enum logic [ACBT_MODE_W-1:0] {
        MODE_LOAD  = 2'd0,
        MODE_BUILD = 2'd1,
        MODE_QUERY = 2'd2,
        MODE_NONE  = 2'd3
    } t_mode;

    typedef enum logic [3:0] {
        ST_CLEAR,
        ST_IDLE,
        ST_LOAD,
        ST_B_INIT,
        ST_B_RD1,
        ST_B_RD2,
        ST_B_WR,
        ST_Q_ALT,
        ST_Q_LIM,
        ST_Q_TGT,
        ST_Q_CMP,
        ST_Q_DONE
    } t_state;

    typedef enum logic [1:0] {
        TBL_BUILD_V,
        TBL_BUILD_MID,
        TBL_QUERY,
        TBL_QUERY_NEXT
    } t_tbl_sel;

    typedef enum logic {
        ALT_S,
        ALT_TGT
    } t_alt_sel;

    typedef struct packed {
        logic     clr_step;
        logic     capture;
        logic     load;
        logic     root_wr;
        logic     b_next;
        logic     lim_ld;
        logic     tgt_ld;
        logic     s_step;
        logic     out_load;
        t_tbl_sel tbl_sel;
        t_alt_sel alt_sel;
    } t_cmd;

    typedef struct packed {
        logic clr_last;
        logic build_last;
        logic lvl_zero;
    } t_sts;

endpackage

`default_nettype wire

[src/acbt_item_if.sv]
`default_nettype none

interface acbt_item_if;
    import acbt_pkg::*;

    logic                         valid;
    logic                         ready;
    logic [ACBT_MODE_W-1:0]       mode;
    logic [ACBT_NODE_W-1:0]       node_index;
    logic [ACBT_NODE_W-1:0]       parent_node;
    logic signed [ACBT_ALT_W-1:0] node_altitude;
    logic signed [ACBT_ALT_W-1:0] climb_budget;

    modport source (
        output valid, mode, node_index, parent_node, node_altitude, climb_budget,
        input  ready
    );

    modport sink (
        input  valid, mode, node_index, parent_node, node_altitude, climb_budget,
        output ready
    );

endinterface

`default_nettype wire

[src/acbt_result_if.sv]
`default_nettype none

interface acbt_result_if;
    import acbt_pkg::*;

    logic                   valid;
    logic                   ready;
    logic [ACBT_NODE_W-1:0] reached_node;

    modport source (
        output valid, reached_node,
        input  ready
    );

    modport sink (
        input  valid, reached_node,
        output ready
    );

endinterface

`default_nettype wire

[src/acbt_cfg_if.sv]
`default_nettype none

interface acbt_cfg_if;
    import acbt_pkg::*;

    logic                      valid;
    logic                      ready;
    logic [ACBT_CFG_IDX_W-1:0] index;
    logic [ACBT_NODE_W-1:0]    data;

    modport source (
        output valid, index, data,
        input  ready
    );

    modport sink (
        input  valid, index, data,
        output ready
    );

endinterface

`default_nettype wire

[src/acbt_datapath.sv]
`default_nettype none

module acbt_datapath #(
    parameter int LEVELS = acbt_pkg::ACBT_LEVELS
) (
    input  wire logic                                 i_clk,
    input  wire logic                                 i_rst_n,
    input  wire logic [acbt_pkg::ACBT_NODE_W-1:0]     i_node_index,
    input  wire logic [acbt_pkg::ACBT_NODE_W-1:0]     i_parent_node,
    input  wire logic signed [acbt_pkg::ACBT_ALT_W-1:0] i_node_altitude,
    input  wire logic signed [acbt_pkg::ACBT_ALT_W-1:0] i_climb_budget,
    input  wire logic                                 i_cfg_we,
    input  wire logic [acbt_pkg::ACBT_CFG_IDX_W-1:0]  i_cfg_index,
    input  wire logic [acbt_pkg::ACBT_NODE_W-1:0]     i_cfg_data,
    input  wire acbt_pkg::t_cmd                       i_cmd,
    output acbt_pkg::t_sts                            o_sts,
    output logic [acbt_pkg::ACBT_NODE_W-1:0]          o_reached_node
);
    import acbt_pkg::*;

    localparam int LEVEL_W   = (LEVELS > 1) ? $clog2(LEVELS) : 1;
    localparam int TBL_AW    = LEVEL_W + ACBT_NODE_W;
    localparam int TBL_DEPTH = LEVELS * ACBT_NODES;
    localparam logic [LEVEL_W-1:0]     LVL_ONE  = LEVEL_W'(1);
    localparam logic [LEVEL_W-1:0]     LVL_TOP  = LEVEL_W'(LEVELS - 1);
    localparam logic [ACBT_NODE_W-1:0] NODE_ONE = ACBT_NODE_W'(1);

    // ancestor table, level in the upper address bits
    logic [ACBT_NODE_W-1:0]       r_tbl_mem [0:TBL_DEPTH-1];
    logic signed [ACBT_ALT_W-1:0] r_alt_mem [0:ACBT_NODES-1];

    logic [ACBT_NODE_W-1:0]         r_root;
    logic [ACBT_NODE_W-1:0]         r_count;
    logic [ACBT_NODE_W-1:0]         r_clr;
    logic [ACBT_NODE_W-1:0]         r_node;
    logic [ACBT_NODE_W-1:0]         r_parent;
    logic signed [ACBT_ALT_W-1:0]   r_alt_in;
    logic signed [ACBT_ALT_W-1:0]   r_budget;
    logic [LEVEL_W-1:0]             r_lvl;
    logic [ACBT_NODE_W-1:0]         r_v;
    logic                           r_root_pass;
    logic signed [ACBT_LIMIT_W-1:0] r_limit;
    logic [ACBT_NODE_W-1:0]         r_tgt;
    logic [ACBT_NODE_W-1:0]         r_tbl_rd;
    logic signed [ACBT_ALT_W-1:0]   r_alt_rd;
    logic [ACBT_NODE_W-1:0]         r_out_node;

    logic                           w_root_in_range;
    logic                           w_first_is_root;
    logic [ACBT_NODE_W-1:0]         w_first_v;
    logic                           w_level_end;
    logic [LEVEL_W-1:0]             w_lvl_dec;
    logic signed [ACBT_LIMIT_W-1:0] w_alt_ext;
    logic [ACBT_NODE_W-1:0]         w_s_next;
    logic [TBL_AW-1:0]              w_tbl_raddr;
    logic [ACBT_NODE_W-1:0]         w_alt_raddr;
    logic                           w_tbl_we;
    logic [TBL_AW-1:0]              w_tbl_waddr;
    logic [ACBT_NODE_W-1:0]         w_tbl_wdata;
    logic                           w_alt_we;
    logic [ACBT_NODE_W-1:0]         w_alt_waddr;
    logic signed [ACBT_ALT_W-1:0]   w_alt_wdata;

    always_comb begin
        w_root_in_range = (r_root != '0) && (r_root <= r_count);
        w_first_is_root = (r_count == '0);
        w_first_v       = w_first_is_root ? r_root : NODE_ONE;
        w_level_end     = r_root_pass || ((r_v == r_count) && w_root_in_range);
        w_lvl_dec       = r_lvl - LVL_ONE;
        w_alt_ext       = {r_alt_rd[ACBT_ALT_W-1], r_alt_rd};
        w_s_next        = (w_alt_ext <= r_limit) ? r_tgt : r_node;

        unique case (i_cmd.tbl_sel)
            TBL_BUILD_V:    w_tbl_raddr = {w_lvl_dec, r_v};
            TBL_BUILD_MID:  w_tbl_raddr = {w_lvl_dec, r_tbl_rd};
            TBL_QUERY:      w_tbl_raddr = {r_lvl, r_node};
            TBL_QUERY_NEXT: w_tbl_raddr = {w_lvl_dec, w_s_next};
            default:        w_tbl_raddr = {r_lvl, r_node};
        endcase

        unique case (i_cmd.alt_sel)
            ALT_S:   w_alt_raddr = r_node;
            ALT_TGT: w_alt_raddr = r_tbl_rd;
            default: w_alt_raddr = r_node;
        endcase

        w_tbl_we = i_cmd.load || i_cmd.root_wr || i_cmd.b_next;
        priority if (i_cmd.load) begin
            w_tbl_waddr = {LEVEL_W'(0), r_node};
            w_tbl_wdata = r_parent;
        end else if (i_cmd.root_wr) begin
            w_tbl_waddr = {LEVEL_W'(0), r_root};
            w_tbl_wdata = r_root;
        end else begin
            w_tbl_waddr = {r_lvl, r_v};
            w_tbl_wdata = r_tbl_rd;
        end

        w_alt_we = i_cmd.clr_step || i_cmd.load;
        priority if (i_cmd.clr_step) begin
            w_alt_waddr = r_clr;
            w_alt_wdata = '0;
        end else begin
            w_alt_waddr = r_node;
            w_alt_wdata = r_alt_in;
        end

        o_sts.clr_last   = (r_clr == '1);
        o_sts.build_last = w_level_end && (r_lvl == LVL_TOP);
        o_sts.lvl_zero   = (r_lvl == '0);
    end

    always_ff @(posedge i_clk) begin
        if (w_tbl_we) begin
            r_tbl_mem[w_tbl_waddr] <= w_tbl_wdata;
        end
        r_tbl_rd <= r_tbl_mem[w_tbl_raddr];
    end

    always_ff @(posedge i_clk) begin
        if (w_alt_we) begin
            r_alt_mem[w_alt_waddr] <= w_alt_wdata;
        end
        r_alt_rd <= r_alt_mem[w_alt_raddr];
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_root  <= '0;
            r_count <= '1;
            r_clr   <= '0;
        end else begin
            if (i_cfg_we) begin
                if (i_cfg_index == REG_ROOT_NODE) begin
                    r_root <= i_cfg_data;
                end else if (i_cfg_index == REG_NODE_COUNT) begin
                    r_count <= i_cfg_data;
                end
            end
            if (i_cmd.clr_step) begin
                r_clr <= r_clr + NODE_ONE;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_lvl       <= '0;
            r_v         <= '0;
            r_root_pass <= 1'b0;
        end else begin
            priority if (i_cmd.capture) begin
                r_lvl <= LVL_TOP;
            end else if (i_cmd.root_wr) begin
                r_lvl       <= LVL_ONE;
                r_v         <= w_first_v;
                r_root_pass <= w_first_is_root;
            end else if (i_cmd.b_next) begin
                if (w_level_end) begin
                    r_lvl       <= r_lvl + LVL_ONE;
                    r_v         <= w_first_v;
                    r_root_pass <= w_first_is_root;
                end else if (r_v == r_count) begin
                    // root outside the swept range gets its own entry
                    r_v         <= r_root;
                    r_root_pass <= 1'b1;
                end else begin
                    r_v <= r_v + NODE_ONE;
                end
            end else if (i_cmd.s_step && (r_lvl != '0)) begin
                r_lvl <= w_lvl_dec;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.capture) begin
            r_node   <= i_node_index;
            r_parent <= i_parent_node;
            r_alt_in <= i_node_altitude;
            r_budget <= i_climb_budget;
        end else if (i_cmd.s_step) begin
            r_node <= w_s_next;
        end
        if (i_cmd.lim_ld) begin
            r_limit <= {r_alt_rd[ACBT_ALT_W-1], r_alt_rd}
                     + {r_budget[ACBT_ALT_W-1], r_budget};
        end
        if (i_cmd.tgt_ld) begin
            r_tgt <= r_tbl_rd;
        end
        if (i_cmd.out_load) begin
            r_out_node <= r_node;
        end
    end

    assign o_reached_node = r_out_node;

endmodule

`default_nettype wire

[src/acbt_ctrl.sv]
`default_nettype none

module acbt_ctrl (
    input  wire logic                             i_clk,
    input  wire logic                             i_rst_n,
    input  wire logic                             i_item_valid,
    input  wire logic [acbt_pkg::ACBT_MODE_W-1:0] i_item_mode,
    input  wire logic                             i_out_ready,
    input  wire acbt_pkg::t_sts                   i_sts,
    output logic                                  o_item_ready,
    output logic                                  o_out_valid,
    output acbt_pkg::t_cmd                        o_cmd
);
    import acbt_pkg::*;

    t_state r_state;
    t_state n_state;
    logic   r_out_valid;
    logic   n_out_valid;
    logic   w_out_free;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= ST_CLEAR;
            r_out_valid <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_out_valid <= n_out_valid;
        end
    end

    always_comb begin
        n_state        = r_state;
        o_cmd          = '0;
        o_cmd.tbl_sel  = TBL_QUERY;
        o_cmd.alt_sel  = ALT_S;
        o_item_ready   = 1'b0;
        w_out_free     = !r_out_valid || i_out_ready;

        unique case (r_state)
            ST_CLEAR: begin
                o_cmd.clr_step = 1'b1;
                if (i_sts.clr_last) begin
                    n_state = ST_IDLE;
                end
            end
            ST_IDLE: begin
                o_item_ready = 1'b1;
                if (i_item_valid) begin
                    o_cmd.capture = 1'b1;
                    unique case (t_mode'(i_item_mode))
                        MODE_LOAD:  n_state = ST_LOAD;
                        MODE_BUILD: n_state = ST_B_INIT;
                        MODE_QUERY: n_state = ST_Q_ALT;
                        MODE_NONE:  n_state = ST_IDLE;
                        default:    n_state = ST_IDLE;
                    endcase
                end
            end
            ST_LOAD: begin
                o_cmd.load = 1'b1;
                n_state    = ST_IDLE;
            end
            ST_B_INIT: begin
                o_cmd.root_wr = 1'b1;
                n_state       = ST_B_RD1;
            end
            ST_B_RD1: begin
                o_cmd.tbl_sel = TBL_BUILD_V;
                n_state       = ST_B_RD2;
            end
            ST_B_RD2: begin
                o_cmd.tbl_sel = TBL_BUILD_MID;
                n_state       = ST_B_WR;
            end
            ST_B_WR: begin
                o_cmd.b_next = 1'b1;
                n_state      = i_sts.build_last ? ST_IDLE : ST_B_RD1;
            end
            ST_Q_ALT: begin
                o_cmd.alt_sel = ALT_S;
                n_state       = ST_Q_LIM;
            end
            ST_Q_LIM: begin
                o_cmd.lim_ld  = 1'b1;
                o_cmd.tbl_sel = TBL_QUERY;
                n_state       = ST_Q_TGT;
            end
            ST_Q_TGT: begin
                o_cmd.tgt_ld  = 1'b1;
                o_cmd.alt_sel = ALT_TGT;
                n_state       = ST_Q_CMP;
            end
            ST_Q_CMP: begin
                o_cmd.s_step  = 1'b1;
                o_cmd.tbl_sel = i_sts.lvl_zero ? TBL_QUERY : TBL_QUERY_NEXT;
                n_state       = i_sts.lvl_zero ? ST_Q_DONE : ST_Q_TGT;
            end
            ST_Q_DONE: begin
                if (w_out_free) begin
                    o_cmd.out_load = 1'b1;
                    n_state        = ST_IDLE;
                end
            end
            default: begin
                n_state = ST_IDLE;
            end
        endcase

        if (o_cmd.out_load) begin
            n_out_valid = 1'b1;
        end else if (i_out_ready) begin
            n_out_valid = 1'b0;
        end else begin
            n_out_valid = r_out_valid;
        end
    end

    assign o_out_valid = r_out_valid;

endmodule

`default_nettype wire

[src/ancestor_climb_by_threshold.sv]
`default_nettype none

// Binary-lifting ancestor climb over a rooted tree of 65536 nodes. Load items store a node's
// parent and altitude, a build item fills the LEVELS-level ancestor table (each entry being
// two dependent reads of the table memory and one write), and a query item returns the
// highest ancestor whose altitude stays within altitude(start) + climb_budget. A query
// steps down the levels from the top, each level needing a table read and then an altitude
// read in turn. Items are taken one at a time; a finished result waits in an output register,
// and the next item is taken meanwhile. After reset the altitude store is cleared to zero,
// during which no item is taken; configuration writes are taken at any time, and must only
// be made while idle.
module ancestor_climb_by_threshold #(
    parameter int LEVELS = acbt_pkg::ACBT_LEVELS
) (
    input  wire logic           i_clk,
    input  wire logic           i_rst_n,
    acbt_item_if.sink           i_item,
    acbt_result_if.source       o_result,
    acbt_cfg_if.sink            i_cfg
);
    import acbt_pkg::*;

    t_cmd w_cmd;
    t_sts w_sts;
    logic w_item_ready;
    logic w_out_valid;

    acbt_ctrl u_ctrl (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_item_valid (i_item.valid),
        .i_item_mode  (i_item.mode),
        .i_out_ready  (o_result.ready),
        .i_sts        (w_sts),
        .o_item_ready (w_item_ready),
        .o_out_valid  (w_out_valid),
        .o_cmd        (w_cmd)
    );

    acbt_datapath #(
        .LEVELS (LEVELS)
    ) u_datapath (
        .i_clk           (i_clk),
        .i_rst_n         (i_rst_n),
        .i_node_index    (i_item.node_index),
        .i_parent_node   (i_item.parent_node),
        .i_node_altitude (i_item.node_altitude),
        .i_climb_budget  (i_item.climb_budget),
        .i_cfg_we        (i_cfg.valid),
        .i_cfg_index     (i_cfg.index),
        .i_cfg_data      (i_cfg.data),
        .i_cmd           (w_cmd),
        .o_sts           (w_sts),
        .o_reached_node  (o_result.reached_node)
    );

    assign i_item.ready   = w_item_ready;
    assign o_result.valid = w_out_valid;
    assign i_cfg.ready    = 1'b1;

    a_clear_blocks_items: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_cmd.clr_step |-> !i_item.ready)
        else $error("item taken during altitude clear");

    a_result_slot_free: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_cmd.out_load |-> (!o_result.valid || o_result.ready))
        else $error("result overwrites one still waiting");

    a_one_table_writer: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $onehot0({w_cmd.load, w_cmd.root_wr, w_cmd.b_next}))
        else $error("two table writes in one cycle");

    a_result_after_level_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_cmd.out_load |-> w_sts.lvl_zero)
        else $error("result loaded before the last level");

    a_result_shown: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_cmd.out_load |=> o_result.valid)
        else $error("loaded result not presented");

endmodule

`default_nettype wire

[dv/tb_ancestor_climb_by_threshold.sv]
`default_nettype none

module tb_ancestor_climb_by_threshold;
    timeunit 1ns;
    timeprecision 1ps;

    import acbt_pkg::*;

    localparam int CYCLE_LIMIT = 3_000_000;
    localparam int PHASE_ITEMS = 150;
    localparam int DIR_ROWS    = 24;
    localparam int QUERY_LAT   = 2 * ACBT_LEVELS + 3;

    localparam logic signed [ACBT_ALT_W-1:0] ALT_MAX = 32'sh7FFF_FFFF;
    localparam logic signed [ACBT_ALT_W-1:0] ALT_MIN = 32'sh8000_0000;

    typedef struct packed {
        t_mode                        mode;
        logic [ACBT_NODE_W-1:0]       node;
        logic [ACBT_NODE_W-1:0]       parent;
        logic signed [ACBT_ALT_W-1:0] altitude;
        logic signed [ACBT_ALT_W-1:0] budget;
        logic                         typed;
        logic [ACBT_NODE_W-1:0]       reached;
    } t_row;

    logic i_clk = 1'b0;
    logic i_rst_n;

    acbt_item_if   item_bus ();
    acbt_result_if result_bus ();
    acbt_cfg_if    cfg_bus ();

    ancestor_climb_by_threshold i_dut (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_item   (item_bus),
        .o_result (result_bus),
        .i_cfg    (cfg_bus)
    );

    bit [ACBT_NODE_W-1:0]   up_tbl [ACBT_LEVELS][ACBT_NODES];
    int                     alt_mem [ACBT_NODES];
    logic [ACBT_NODE_W-1:0] root_reg  = '0;
    logic [ACBT_NODE_W-1:0] count_reg = '1;
    logic [ACBT_NODE_W-1:0] built_root;
    logic [ACBT_NODE_W-1:0] built_count;
    logic [ACBT_NODE_W-1:0] reached_q [$];
    int                     errors        = 0;
    int                     cycles        = 0;
    int                     stall_left    = 0;
    bit                     calm          = 1'b0;
    bit                     build_pending = 1'b0;
    t_row                   dir_tbl [DIR_ROWS];

    always begin
        #5 i_clk = 1'b1;
        #5 i_clk = 1'b0;
    end

    always @(posedge i_clk) begin
        cycles <= cycles + 1;
        if (cycles >= CYCLE_LIMIT) begin
            $display("== FAIL ==");
            $finish;
        end
    end

    task automatic report_mismatch(string msg);
        errors++;
        $display("[%0t] mismatch: %s", $time, msg);
    endtask

    function automatic int pick_gap();
        int r;
        if (calm)
            return 0;
        r = $urandom_range(0, 99);
        if (r < 55)
            return 0;
        if (r < 93)
            return $urandom_range(1, 3);
        return $urandom_range(10, 40);
    endfunction

    function automatic logic signed [ACBT_ALT_W-1:0] rand_level();
        case ($urandom_range(0, 9))
            7:       return $urandom;
            8:       return ALT_MAX;
            9:       return ALT_MIN;
            default: return int'($urandom_range(0, 400)) - 200;
        endcase
    endfunction

    function automatic bit in_tree(logic [ACBT_NODE_W-1:0] v, logic [ACBT_NODE_W-1:0] root,
                                   logic [ACBT_NODE_W-1:0] count);
        return v == root || (v >= 1 && v <= count);
    endfunction

    function automatic logic [ACBT_NODE_W-1:0] pick_member(logic [ACBT_NODE_W-1:0] root,
                                                           logic [ACBT_NODE_W-1:0] count);
        int r;
        r = $urandom_range(0, int'(count));
        return (r == 0) ? root : ACBT_NODE_W'(r);
    endfunction

    function automatic void store_node(logic [ACBT_NODE_W-1:0] v, logic [ACBT_NODE_W-1:0] p,
                                       logic signed [ACBT_ALT_W-1:0] a);
        up_tbl[0][v] = p;
        alt_mem[v]   = a;
    endfunction

    // each level only reads the one below, so the root can go first
    function automatic void fill_lifting_table();
        logic [ACBT_NODE_W-1:0] v;
        logic [ACBT_NODE_W-1:0] mid;
        up_tbl[0][root_reg] = root_reg;
        for (int lvl = 1; lvl < ACBT_LEVELS; lvl++) begin
            for (int k = 0; k <= int'(count_reg); k++) begin
                v = (k == 0) ? root_reg : ACBT_NODE_W'(k);
                if (k != 0 || !(root_reg >= 1 && root_reg <= count_reg)) begin
                    mid = up_tbl[lvl-1][v];
                    up_tbl[lvl][v] = up_tbl[lvl-1][mid];
                end
            end
        end
    endfunction

    function automatic logic [ACBT_NODE_W-1:0] climb_from(logic [ACBT_NODE_W-1:0] start,
                                                          logic signed [ACBT_ALT_W-1:0] budget);
        logic [ACBT_NODE_W-1:0] s;
        logic [ACBT_NODE_W-1:0] t;
        longint                 lim;
        s   = start;
        lim = longint'(alt_mem[start]) + longint'(budget);
        for (int lvl = ACBT_LEVELS - 1; lvl >= 0; lvl--) begin
            t = up_tbl[lvl][s];
            if (longint'(alt_mem[t]) <= lim)
                s = t;
        end
        return s;
    endfunction

    always @(posedge i_clk) begin
        logic [ACBT_NODE_W-1:0] want;
        if (i_rst_n && result_bus.valid && result_bus.ready) begin
            if (reached_q.size() == 0) begin
                report_mismatch($sformatf("reached_node %0d with no query pending",
                                          result_bus.reached_node));
            end else begin
                want = reached_q.pop_front();
                if (result_bus.reached_node !== want)
                    report_mismatch($sformatf("reached_node got %0d expected %0d",
                                              result_bus.reached_node, want));
            end
        end
    end

    initial begin
        result_bus.ready = 1'b0;
        forever begin
            @(negedge i_clk);
            if (stall_left > 0) begin
                result_bus.ready <= 1'b0;
                stall_left--;
            end else begin
                result_bus.ready <= 1'b1;
                stall_left = pick_gap();
            end
        end
    end

    task automatic send_item(t_mode m, logic [ACBT_NODE_W-1:0] node,
                             logic [ACBT_NODE_W-1:0] parent,
                             logic signed [ACBT_ALT_W-1:0] altitude,
                             logic signed [ACBT_ALT_W-1:0] budget,
                             bit typed = 1'b0, logic [ACBT_NODE_W-1:0] reached = '0);
        int                     gap;
        logic [ACBT_NODE_W-1:0] expect_node;
        gap = pick_gap();
        @(negedge i_clk);
        if (gap > 0) begin
            item_bus.valid <= 1'b0;
            repeat (gap) @(negedge i_clk);
        end
        item_bus.valid         <= 1'b1;
        item_bus.mode          <= m;
        item_bus.node_index    <= node;
        item_bus.parent_node   <= parent;
        item_bus.node_altitude <= altitude;
        item_bus.climb_budget  <= budget;
        do @(posedge i_clk); while (!item_bus.ready);
        case (m)
            MODE_LOAD: begin
                store_node(node, parent, altitude);
            end
            MODE_BUILD: begin
                fill_lifting_table();
                built_root    = root_reg;
                built_count   = count_reg;
                build_pending = 1'b1;
            end
            MODE_QUERY: begin
                expect_node = typed ? reached : climb_from(node, budget);
                reached_q.insert(reached_q.size(), expect_node);
                build_pending = 1'b0;
            end
            default: ;
        endcase
    endtask

    task automatic write_reg(logic [ACBT_CFG_IDX_W-1:0] idx, logic [ACBT_NODE_W-1:0] data);
        @(negedge i_clk);
        cfg_bus.valid <= 1'b1;
        cfg_bus.index <= idx;
        cfg_bus.data  <= data;
        do @(posedge i_clk); while (!cfg_bus.ready);
        @(negedge i_clk);
        cfg_bus.valid <= 1'b0;
        if (idx == REG_ROOT_NODE)
            root_reg = data;
        else
            count_reg = data;
    endtask

    // a build gives no result, so its length is waited out explicitly
    task automatic settle_block();
        @(negedge i_clk);
        item_bus.valid <= 1'b0;
        while (reached_q.size() != 0) @(posedge i_clk);
        repeat (build_pending ? 3 * ACBT_LEVELS * (int'(built_count) + 2) + 64
                              : QUERY_LAT + 16) @(posedge i_clk);
        build_pending = 1'b0;
    endtask

    task automatic load_tree();
        int r;
        send_item(MODE_LOAD, root_reg, 16'($urandom), rand_level(), $urandom);
        for (int v = 1; v <= int'(count_reg); v++) begin
            r = $urandom_range(0, v - 1);
            send_item(MODE_LOAD, ACBT_NODE_W'(v), (r == 0) ? root_reg : ACBT_NODE_W'(r),
                      rand_level(), $urandom);
        end
        send_item(MODE_BUILD, 16'($urandom), 16'($urandom), $urandom, $urandom);
    endtask

    task automatic run_random(int n);
        int                     r;
        logic [ACBT_NODE_W-1:0] v;
        logic [ACBT_NODE_W-1:0] p;
        for (int i = 0; i < n; i++) begin
            r = $urandom_range(0, 99);
            if (r < 58) begin
                send_item(MODE_QUERY, pick_member(built_root, built_count), 16'($urandom),
                          $urandom, rand_level());
            end else if (r < 80) begin
                v = pick_member(built_root, built_count);
                send_item(MODE_LOAD, v, pick_member(built_root, built_count), rand_level(),
                          $urandom);
            end else if (r < 88) begin
                v = 16'($urandom);
                p = in_tree(v, built_root, built_count) ? pick_member(built_root, built_count)
                                                        : 16'($urandom);
                send_item(MODE_LOAD, v, p, rand_level(), $urandom);
            end else if (r < 91 && root_reg == built_root && count_reg == built_count) begin
                send_item(MODE_BUILD, 16'($urandom), 16'($urandom), $urandom, $urandom);
            end else begin
                send_item(MODE_NONE, 16'($urandom), 16'($urandom), $urandom, $urandom);
            end
        end
    endtask

    task automatic run_phase(logic [ACBT_NODE_W-1:0] root, logic [ACBT_NODE_W-1:0] count,
                             bit rebuild, int n);
        settle_block();
        calm = ($urandom_range(0, 3) == 0);
        write_reg(REG_ROOT_NODE, root);
        write_reg(REG_NODE_COUNT, count);
        if (rebuild)
            load_tree();
        run_random(n);
    endtask

    initial begin
        int cnt;
        i_rst_n                = 1'b0;
        item_bus.valid         = 1'b0;
        item_bus.mode          = MODE_NONE;
        item_bus.node_index    = '0;
        item_bus.parent_node   = '0;
        item_bus.node_altitude = '0;
        item_bus.climb_budget  = '0;
        cfg_bus.valid          = 1'b0;
        cfg_bus.index          = REG_ROOT_NODE;
        cfg_bus.data           = '0;

        dir_tbl = '{
            '{MODE_NONE,  16'hFFFF, 16'hFFFF, ALT_MAX, ALT_MIN, 1'b0, 16'd0},
            // root parent is forced by the build
            '{MODE_LOAD,  16'd0,    16'hFFFF, 0,       0,       1'b0, 16'd0},
            '{MODE_LOAD,  16'd1,    16'd0,    ALT_MAX, 0,       1'b0, 16'd0},
            '{MODE_LOAD,  16'd2,    16'd0,    ALT_MIN, 0,       1'b0, 16'd0},
            '{MODE_LOAD,  16'd3,    16'd1,    7,       0,       1'b0, 16'd0},
            '{MODE_LOAD,  16'd4,    16'd3,    3,       0,       1'b0, 16'd0},
            '{MODE_BUILD, 16'hA5A5, 16'h5A5A, ALT_MIN, ALT_MAX, 1'b0, 16'd0},
            // threshold past 32 bits on both sides
            '{MODE_QUERY, 16'd1,    16'd0,    0,       ALT_MAX, 1'b1, 16'd0},
            '{MODE_QUERY, 16'd2,    16'd0,    0,       ALT_MIN, 1'b1, 16'd2},
            '{MODE_QUERY, 16'd0,    16'd0,    0,       ALT_MIN, 1'b1, 16'd0},
            '{MODE_QUERY, 16'd3,    16'd0,    0,       ALT_MAX, 1'b1, 16'd0},
            '{MODE_QUERY, 16'd3,    16'd0,    0,       ALT_MIN, 1'b1, 16'd3},
            '{MODE_QUERY, 16'd4,    16'd0,    0,       4,       1'b0, 16'd0},
            '{MODE_QUERY, 16'd4,    16'd0,    0,       -4,      1'b0, 16'd0},
            '{MODE_QUERY, 16'd3,    16'd0,    0,       0,       1'b0, 16'd0},
            // reparent after the build, upper levels stay stale
            '{MODE_LOAD,  16'd3,    16'd0,    -20,     0,       1'b0, 16'd0},
            '{MODE_QUERY, 16'd4,    16'd0,    0,       0,       1'b0, 16'd0},
            '{MODE_QUERY, 16'd3,    16'd0,    0,       25,      1'b0, 16'd0},
            '{MODE_NONE,  16'd0,    16'd0,    0,       0,       1'b0, 16'd0},
            '{MODE_BUILD, 16'd0,    16'd0,    0,       0,       1'b0, 16'd0},
            '{MODE_QUERY, 16'd4,    16'd0,    0,       ALT_MAX, 1'b1, 16'd0},
            '{MODE_QUERY, 16'd4,    16'd0,    0,       0,       1'b0, 16'd0},
            '{MODE_LOAD,  16'd0,    16'd2,    ALT_MAX, 0,       1'b0, 16'd0},
            '{MODE_QUERY, 16'd4,    16'd0,    0,       ALT_MAX, 1'b0, 16'd0}
        };

        repeat (5) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n <= 1'b1;

        write_reg(REG_ROOT_NODE, 16'd0);
        write_reg(REG_NODE_COUNT, 16'd4);
        foreach (dir_tbl[k])
            send_item(dir_tbl[k].mode, dir_tbl[k].node, dir_tbl[k].parent,
                      dir_tbl[k].altitude, dir_tbl[k].budget, dir_tbl[k].typed,
                      dir_tbl[k].reached);

        run_phase(16'hFFFF, 16'($urandom_range(8, 30)), 1'b1, PHASE_ITEMS);
        cnt = $urandom_range(10, 40);
        run_phase(16'($urandom_range(1, cnt)), 16'(cnt), 1'b1, PHASE_ITEMS);
        run_phase(16'($urandom), 16'd1, 1'b1, PHASE_ITEMS);
        run_phase(16'($urandom), 16'($urandom_range(150, 250)), 1'b1, PHASE_ITEMS);
        run_phase(16'd0, 16'($urandom_range(2, 20)), 1'b1, PHASE_ITEMS);
        // full count with the last table kept, no rebuild
        run_phase(16'd0, 16'hFFFF, 1'b0, PHASE_ITEMS);
        settle_block();

        if (errors == 0)
            $display("== PASS ==");
        else
            $display("== FAIL ==");
        $finish;
    end

endmodule

`default_nettype wire
